[rtl/lbrle_pkg.sv]
// Package: shared types, register indexes and constants of the lossy block run-length encoder.
`default_nettype none
package lbrle_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned PIXEL_W  = 3 * CHAN_W;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned DIFF_W   = 10;
    localparam int unsigned SIDE_W   = 8;
    localparam int unsigned POS_W    = 2 * SIDE_W;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = DIFF_W;
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CNT_W = OQ_PTR_W + 1;

    localparam logic [COUNT_W-1:0] RUN_LIMIT = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE     = 2'd2;

    // Reset values
    localparam logic [DIFF_W-1:0] THRESH_RST    = 10'd1;
    localparam logic [POS_W-1:0]  LAST_POS_RST  = 16'd63;

    typedef struct packed {
        logic [DIFF_W-1:0] thresh;
        logic              compress;
        logic [POS_W-1:0]  last_pos;   // index of the last pixel in a block
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [COUNT_W-1:0] count;
        logic               ends_block;
        logic               last;
    } t_result;

endpackage
`default_nettype wire

[rtl/lbrle_cfg.sv]
// Configuration registers with the block's last pixel index precomputed.
`default_nettype none
module lbrle_cfg
    import lbrle_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg              r_cfg;
    logic [SIDE_W-1:0] side;
    logic [POS_W-1:0]  area;

    always_comb begin
        side = i_cfg_wdata[SIDE_W-1:0];
        // treat a side of zero as a one-pixel block
        if (side == '0) begin
            side = SIDE_W'(1);
        end
        area = POS_W'(side) * POS_W'(side);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh   <= THRESH_RST;
            r_cfg.compress <= 1'b0;
            r_cfg.last_pos <= LAST_POS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESH:   r_cfg.thresh   <= i_cfg_wdata;
                REG_COMPRESS: r_cfg.compress <= i_cfg_wdata[0];
                REG_SIDE:     r_cfg.last_pos <= area - POS_W'(1);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/lbrle_core.sv]
// Pixel input register, run compare and run state update.
`default_nettype none
module lbrle_core
    import lbrle_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [PIXEL_W-1:0] i_pixel,   // red in bits 23..16
    input  wire logic               i_space,   // queue can take two results
    output logic [1:0]              o_push_n,
    output t_result                 o_res_a,
    output t_result                 o_res_b
);

    logic               r_in_valid;
    logic [PIXEL_W-1:0] r_px;
    logic [PIXEL_W-1:0] r_rep;
    logic [COUNT_W-1:0] r_len;
    logic [POS_W-1:0]   r_pos;

    logic [PIXEL_W-1:0] n_rep;
    logic [COUNT_W-1:0] n_len;
    logic               fire;
    logic               first;
    logic               ovf;
    logic               diff_over;
    logic               closed;
    logic               block_end;
    logic [CHAN_W-1:0]  ad_r, ad_g, ad_b;
    logic [DIFF_W-1:0]  dsum;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign fire    = r_in_valid && i_space;
    assign o_ready = !r_in_valid || fire;

    always_comb begin
        ad_r = abs_diff(r_rep[23:16], r_px[23:16]);
        ad_g = abs_diff(r_rep[15:8],  r_px[15:8]);
        ad_b = abs_diff(r_rep[7:0],   r_px[7:0]);
        dsum = DIFF_W'(ad_r) + DIFF_W'(ad_g) + DIFF_W'(ad_b);

        first     = (r_pos == '0);
        ovf       = !first && (r_len == RUN_LIMIT);
        diff_over = dsum > i_cfg.thresh;
        closed    = !first && (ovf || diff_over);
        block_end = r_pos >= i_cfg.last_pos;

        if (first) begin
            n_rep = r_px;
        end else if (ovf) begin
            n_rep = i_cfg.compress ? r_rep : r_px;
        end else if (diff_over) begin
            n_rep = r_px;
        end else begin
            n_rep = r_rep;
        end
        n_len = (first || closed) ? COUNT_W'(1) : r_len + COUNT_W'(1);
    end

    // closed run goes first, then the run that ends the block
    always_comb begin
        t_result closed_res;
        t_result end_res;
        closed_res.red        = r_rep[23:16];
        closed_res.green      = r_rep[15:8];
        closed_res.blue       = r_rep[7:0];
        closed_res.count      = r_len;
        closed_res.ends_block = 1'b0;
        closed_res.last       = !block_end;
        end_res.red           = n_rep[23:16];
        end_res.green         = n_rep[15:8];
        end_res.blue          = n_rep[7:0];
        end_res.count         = n_len;
        end_res.ends_block    = 1'b1;
        end_res.last          = 1'b1;
        o_res_a  = closed ? closed_res : end_res;
        o_res_b  = end_res;
        o_push_n = fire ? (2'(closed) + 2'(block_end)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_rep      <= '0;
            r_len      <= '0;
            r_pos      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_rep <= n_rep;
                if (block_end) begin
                    r_len <= '0;
                    r_pos <= '0;
                end else begin
                    r_len <= n_len;
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_px <= i_pixel;
        end
    end

`ifndef ASSERT_OFF
    a_end_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && block_end |=> (r_pos == '0) && (r_len == '0))
        else $error("block end did not clear position and length");
    a_close_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && closed && !block_end |=> (r_len == COUNT_W'(1)))
        else $error("closed run did not restart at length one");
    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (r_len != '0))
        else $error("open run inside a block has zero length");
`endif

endmodule
`default_nettype wire

[rtl/lbrle_outq.sv]
// Four-entry result queue; takes up to two results per cycle.
`default_nettype none
module lbrle_outq
    import lbrle_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic [1:0] i_push_n,
    input  wire t_result    i_res_a,
    input  wire t_result    i_res_b,
    output logic       o_space,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_res
);

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wptr;
    logic [OQ_PTR_W-1:0] r_rptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    assign o_space = r_count <= OQ_CNT_W'(OQ_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + OQ_PTR_W'(i_push_n);
            r_rptr  <= r_rptr + OQ_PTR_W'(pop);
            r_count <= r_count + OQ_CNT_W'(i_push_n) - OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_res_a;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wptr + OQ_PTR_W'(1)] <= i_res_b;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_space)
        else $error("push into a queue without room for two results");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("queue count beyond depth");
    a_push_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n != 2'd3)
        else $error("more than two results from one pixel");
`endif

endmodule
`default_nettype wire

[rtl/lossy_block_run_length_encoder_top.sv]
// Top level of the lossy block run-length encoder.
// Pixels enter in block-scan order (square blocks of side by side pixels, raster
// order inside a block) and leave as runs: a representative pixel and a count of
// 1..255. A pixel extends the open run while |dR|+|dG|+|dB| against the
// representative is at most the difference threshold; a run that has reached 255
// pixels is closed by the next pixel, which opens a run that keeps the old
// representative when the repeat flag is set. The last pixel of a block always
// emits the open run with ends_block (o_m_tlast) set; a pixel can emit two runs,
// and the final run caused by a pixel carries the last flag in o_m_tuser. Rate:
// one pixel per clock, sustained while the sink takes a run every cycle and
// pixels emit no more than one run per cycle on average. A pixel is latched in an
// input register, compared and folded into the run state when there is room, and
// its runs are written into a four-entry result queue; the input stalls only
// while a pixel waits in the input register and that queue holds more than two
// runs, which happens when the sink stalls or when two-run pixels come faster
// than one run per cycle drains. The first run of a pixel appears on the output
// once it is written into the result queue. Register writes (index 0 difference
// threshold, 1 repeat flag, 2 block side) take effect on the next cycle and are
// meant for idle periods; a block side of 0 or 1 gives one-pixel blocks.
`default_nettype none
module lossy_block_run_length_encoder_top
    import lbrle_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // pixel stream in
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [23:0]          i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // run stream out
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [31:0]               o_m_tdata,   // run_red[7:0], run_green[15:8],
                                                   // run_blue[23:16], run_count[31:24]
    output logic                      o_m_tuser,   // last[0]
    output logic                      o_m_tlast    // ends_block
);

    t_cfg               cfg;
    logic               space;
    logic [1:0]         push_n;
    t_result            res_a;
    t_result            res_b;
    t_result            res_out;
    logic [PIXEL_W-1:0] pixel;

    // hold the pixel with red in the upper byte, as the run state keeps it
    assign pixel = {i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]};

    lbrle_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lbrle_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_pixel  (pixel),
        .i_space  (space),
        .o_push_n (push_n),
        .o_res_a  (res_a),
        .o_res_b  (res_b)
    );

    lbrle_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res_a  (res_a),
        .i_res_b  (res_b),
        .o_space  (space),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_res    (res_out)
    );

    // drive the run fields onto the output bus, first field in the low byte
    assign o_m_tdata = {res_out.count, res_out.blue, res_out.green, res_out.red};
    assign o_m_tuser = res_out.last;
    assign o_m_tlast = res_out.ends_block;

endmodule
`default_nettype wire

[sim/lbrle_run_checker.sv]
// Run checker: watches both streams, predicts the runs of each pixel and compares them.
module lbrle_run_checker
    import lbrle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [23:0]          i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [31:0]          i_m_tdata,   // run_red[7:0], run_green[15:8],
                                              // run_blue[23:16], run_count[31:24]
    input  logic                 i_m_tuser,   // last[0]
    input  logic                 i_m_tlast,   // ends_block
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SIDE_W-1:0] SIDE_RST = 8'd8;

    // register mirror
    logic [DIFF_W-1:0]  thresh_q;
    logic               compress_q;
    logic [SIDE_W-1:0]  side_q;

    // encoder state
    logic [PIXEL_W-1:0] rep_px;       // same layout as the input item
    logic [COUNT_W-1:0] run_len;
    logic [POS_W-1:0]   blk_pos;

    t_result expected_runs[$];
    int      fails = 0;

    function automatic int chan_dist(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic t_result open_run(logic ends, logic fin);
        t_result run;
        run.red        = rep_px[7:0];
        run.green      = rep_px[15:8];
        run.blue       = rep_px[23:16];
        run.count      = run_len;
        run.ends_block = ends;
        run.last       = fin;
        return run;
    endfunction

    task automatic encode_pixel(input logic [PIXEL_W-1:0] px);
        int      side;
        int      gap;
        logic    block_end;
        logic    closed;
        t_result closed_run;
        side      = (side_q == '0) ? 1 : int'(side_q);
        block_end = int'(blk_pos) >= side * side - 1;
        closed    = 1'b0;
        if (blk_pos == '0) begin
            rep_px  = px;
            run_len = COUNT_W'(1);
        end else if (run_len == RUN_LIMIT) begin
            // full run: close it without comparing
            closed     = 1'b1;
            closed_run = open_run(1'b0, !block_end);
            if (!compress_q) rep_px = px;
            run_len = COUNT_W'(1);
        end else begin
            gap = chan_dist(rep_px[7:0], px[7:0]) + chan_dist(rep_px[15:8], px[15:8])
                + chan_dist(rep_px[23:16], px[23:16]);
            if (gap <= int'(thresh_q)) begin
                run_len = run_len + 1'b1;
            end else begin
                closed     = 1'b1;
                closed_run = open_run(1'b0, !block_end);
                rep_px     = px;
                run_len    = COUNT_W'(1);
            end
        end
        if (closed) expected_runs.push_back(closed_run);
        if (block_end) begin
            expected_runs.push_back(open_run(1'b1, 1'b1));
            run_len = '0;
            blk_pos = '0;
        end else begin
            blk_pos = blk_pos + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t ns: run field %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            thresh_q   = THRESH_RST;
            compress_q = 1'b0;
            side_q     = SIDE_RST;
            rep_px     = '0;
            run_len    = '0;
            blk_pos    = '0;
            expected_runs.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_runs.size() == 0) begin
                    fails++;
                    $display("%0t ns: unexpected run, expected none, actual %h user %b last %b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                end else begin
                    want = expected_runs.pop_front();
                    check_field("run_red",    int'(want.red),        int'(i_m_tdata[7:0]));
                    check_field("run_green",  int'(want.green),      int'(i_m_tdata[15:8]));
                    check_field("run_blue",   int'(want.blue),       int'(i_m_tdata[23:16]));
                    check_field("run_count",  int'(want.count),      int'(i_m_tdata[31:24]));
                    check_field("ends_block", int'(want.ends_block), int'(i_m_tlast));
                    check_field("last",       int'(want.last),       int'(i_m_tuser));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESH:   thresh_q   = i_cfg_wdata;
                    REG_COMPRESS: compress_q = i_cfg_wdata[0];
                    REG_SIDE:     side_q     = i_cfg_wdata[SIDE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) encode_pixel(i_s_tdata);
        end
        o_fail_count <= fails;
        o_pending    <= expected_runs.size();
    end

endmodule

[sim/lossy_block_run_length_encoder_top_tb.sv]
// Testbench top: drives pixels and register writes into the encoder and reports the verdict.
module lossy_block_run_length_encoder_top_tb
    import lbrle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic [23:0]          i_s_tdata   = '0;   // red[7:0], green[15:8], blue[23:16]
    logic                 i_m_tready  = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [31:0]          o_m_tdata;          // run_red, run_green, run_blue, run_count
    logic                 o_m_tuser;          // last
    logic                 o_m_tlast;          // ends_block

    int          fail_count;
    int          pending;
    int          idle_pct  = 0;   // chance in a hundred that the source idles a cycle
    int          stall_pct = 0;   // chance in a hundred that the sink stalls a cycle
    logic [23:0] last_px   = '0;

    lossy_block_run_length_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    lbrle_run_checker u_run_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Sink: stall at the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one pixel, idling first at the phase rate, and hold it until accepted.
    // Return at the edge that took it, so the next pixel follows back to back.
    task automatic push_pixel(input logic [23:0] px);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted run has come out. Pixels that
    // close no run may still sit in the pipeline, so the task keeps clocking after that.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; only call while idle.
    task automatic write_regs(input logic [DIFF_W-1:0] md, input logic cmp,
                              input logic [SIDE_W-1:0] bs);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_THRESH;
        i_cfg_wdata <= md;
        @(posedge i_clk);
        i_cfg_idx   <= REG_COMPRESS;
        i_cfg_wdata <= CFG_DAT_W'(cmp);
        @(posedge i_clk);
        i_cfg_idx   <= REG_SIDE;
        i_cfg_wdata <= CFG_DAT_W'(bs);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Pixel source with some texture: repeats and near neighbors build runs,
    // fully random pixels break them and reach every bit.
    function automatic logic [23:0] next_pixel(logic [23:0] prev);
        int          pick;
        logic [23:0] px;
        pick = $urandom_range(9);
        if (pick < 3) begin
            px = 24'($urandom);
        end else if (pick < 6) begin
            px = prev;
        end else begin
            for (int c = 0; c < 3; c++)
                px[c*8 +: 8] = prev[c*8 +: 8] + 8'($urandom_range(4)) - 8'd2;
        end
        return px;
    endfunction

    // One phase: settle, reprogram, then stream n textured pixels. Now and then
    // hold the source until the encoder has emitted everything.
    task automatic run_phase(input logic [DIFF_W-1:0] md, input logic cmp,
                             input logic [SIDE_W-1:0] bs, input int n,
                             input int idle, input int stall);
        wait_drained();
        write_regs(md, cmp, bs);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) begin
            last_px = next_pixel(last_px);
            push_pixel(last_px);
            if ($urandom_range(49) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full channel swing still extends a run at the widest threshold.
        write_regs(10'd765, 1'b0, 8'd2);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);

        // Threshold edge: a distance of the threshold extends, one more closes the run.
        wait_drained();
        write_regs(10'd1, 1'b0, 8'd2);
        push_pixel(24'h101010);
        push_pixel(24'h111010);
        push_pixel(24'h111110);
        push_pixel(24'h111110);

        // Last pixel of a block that also breaks the run: two runs from one pixel.
        push_pixel(24'hAA55AA);
        push_pixel(24'hAA55AA);
        push_pixel(24'hAA55AA);
        push_pixel(24'h00FF00);

        // Block side zero: every pixel is a block of its own.
        wait_drained();
        write_regs(10'd0, 1'b1, 8'd0);
        push_pixel(24'h123456);
        push_pixel(24'h123456);
        push_pixel(24'hFFFFFF);

        // Random phases over thresholds, block sides and idling patterns.
        run_phase(10'd40,   1'b0, 8'd2,  10, 0,  0);
        run_phase(10'd0,    1'b1, 8'd3,  8,  83, 0);
        run_phase(10'd100,  1'b0, 8'd4,  8,  0,  83);
        run_phase(10'd1023, 1'b1, 8'd5,  10, 8,  8);
        run_phase(10'd20,   1'b0, 8'd0,  6,  8,  8);
        // Length overflow on the last pixel of a 16x16 block, new run takes the pixel.
        run_phase(10'd765,  1'b0, 8'd16, 256, 83, 0);
        // Length overflow mid-block, new run keeps the old representative;
        // stop on the overflowing pixel, deep inside the 17x17 block.
        run_phase(10'd765,  1'b1, 8'd17, 256, 8, 83);
        // Shrink the block below the current position: the next pixel ends it.
        run_phase(10'd1,    1'b0, 8'd2,  4,  0,  0);
        run_phase(10'd765,  1'b1, 8'd1,  4,  83, 83);
        // Largest side for a short while, then shrink to a side still past it.
        run_phase(10'd300,  1'b0, 8'd255, 6, 0, 83);
        run_phase(10'd50,   1'b1, 8'd6,  8,  8,  8);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
